// ===== rtl/awas_pkg.sv =====
// ----------------------------------------------------------------------------
// awas_pkg: shared types and constants of the window average block
// Sample layout, configuration register map and reset values.
// ----------------------------------------------------------------------------
package awas_pkg;

  localparam int unsigned DefWindow = 16;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;

  // configuration register map
  localparam logic [CfgIdxW-1:0] RegThreshold   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegStableCount = 8'd1;

  localparam logic [15:0] ThresholdReset   = 16'd64;
  localparam logic [7:0]  StableCountReset = 8'd10;

  // one three-axis sample, x in the lowest bits
  typedef struct packed {
    logic signed [SampleW-1:0] z;
    logic signed [SampleW-1:0] y;
    logic signed [SampleW-1:0] x;
  } sample_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [7:0]  stable_count;
  } cfg_t;

endpackage

// ===== rtl/awas_cell.sv =====
// ----------------------------------------------------------------------------
// awas_cell: one entry of the sample window
// Takes its neighbor's sample on every request, or the new sample while
// the window is being filled by the first request.
// ----------------------------------------------------------------------------
module awas_cell (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic             fill_i,
  input  awas_pkg::sample_t fill_data_i,
  input  awas_pkg::sample_t prev_i,
  output awas_pkg::sample_t data_o
);

  awas_pkg::sample_t data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= fill_i ? fill_data_i : prev_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/awas_judge.sv =====
// ----------------------------------------------------------------------------
// awas_judge: stillness verdict and output register
// Compares window sums of consecutive requests, tracks the group and
// divides the sums down to window averages.
// ----------------------------------------------------------------------------
module awas_judge #(
  parameter int unsigned WINDOW = awas_pkg::DefWindow
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [awas_pkg::SampleW+$clog2(WINDOW)-1:0] sum_i [3],
  input  awas_pkg::cfg_t                        cfg_i,
  output logic                                  m_valid_o,
  input  logic                                  m_ready_i,
  output awas_pkg::sample_t                     avg_o,
  output logic                                  verdict_o,
  output logic                                  stable_o
);

  localparam int unsigned LogW = $clog2(WINDOW);
  localparam int unsigned SumW = awas_pkg::SampleW + LogW;

  logic signed [SumW-1:0] prev_q [3];
  logic signed [SumW-1:0] prev_d [3];
  logic [7:0]             run_q, run_d;
  logic                   in_group_q, in_group_d;
  logic                   stable_q, stable_d;
  logic                   verdict_d;
  logic                   out_v_q;
  logic                   out_verdict_q;
  awas_pkg::sample_t      avg_q;
  logic [awas_pkg::SampleW-1:0] avg_d [3];

  logic [SumW-1:0]        limit;
  logic signed [SumW:0]   limit_s;
  logic signed [SumW:0]   diff [3];
  logic                   far;
  logic                   adv;

  assign ready_o = !out_v_q || m_ready_i;
  assign adv     = valid_i && ready_o;

  assign limit   = SumW'(cfg_i.threshold) * SumW'(WINDOW);
  assign limit_s = $signed({1'b0, limit});

  always_comb begin
    far = 1'b0;
    for (int a = 0; a < 3; a++) begin
      diff[a] = {sum_i[a][SumW-1], sum_i[a]} - {prev_q[a][SumW-1], prev_q[a]};
      if ((diff[a] > limit_s) || (diff[a] < -limit_s)) begin
        far = 1'b1;
      end
    end
  end

  always_comb begin
    prev_d     = prev_q;
    run_d      = run_q;
    in_group_d = in_group_q;
    stable_d   = stable_q;
    verdict_d  = 1'b0;
    if (!in_group_q) begin
      prev_d     = sum_i;
      run_d      = '0;
      in_group_d = 1'b1;
    end else if (far) begin
      stable_d   = 1'b0;
      in_group_d = 1'b0;
      verdict_d  = 1'b1;
    end else begin
      run_d  = run_q + 8'd1;
      prev_d = sum_i;
    end
    // group closes as soon as enough close comparisons are in
    if (in_group_d && (run_d >= cfg_i.stable_count)) begin
      stable_d   = 1'b1;
      in_group_d = 1'b0;
      verdict_d  = 1'b1;
    end
  end

  // floor division of each sum by the window length
  if ((WINDOW & (WINDOW - 1)) == 0) begin : g_shift
    for (genvar a = 0; a < 3; a++) begin : g_axis
      assign avg_d[a] = sum_i[a][LogW+awas_pkg::SampleW-1:LogW];
    end
  end else begin : g_recip
    // bias to non-negative, multiply by a rounded-up reciprocal, unbias
    localparam int unsigned K     = SumW + LogW;
    localparam int unsigned ProdW = 2 * SumW + 1;
    localparam logic [63:0] Mul   = ((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [63:0] Bias  = 64'd32768 * 64'(WINDOW);
    for (genvar a = 0; a < 3; a++) begin : g_axis
      logic [SumW-1:0]  biased;
      logic [ProdW-1:0] prod;
      assign biased   = sum_i[a] + Bias[SumW-1:0];
      assign prod     = ProdW'(biased) * ProdW'(Mul[SumW:0]);
      assign avg_d[a] = prod[K+awas_pkg::SampleW-1:K] ^ 16'h8000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q        <= '{default: '0};
      run_q         <= '0;
      in_group_q    <= 1'b0;
      stable_q      <= 1'b1;
      out_v_q       <= 1'b0;
      out_verdict_q <= 1'b0;
    end else begin
      if (ready_o) begin
        out_v_q <= valid_i;
      end
      if (adv) begin
        prev_q        <= prev_d;
        run_q         <= run_d;
        in_group_q    <= in_group_d;
        stable_q      <= stable_d;
        out_verdict_q <= verdict_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      avg_q.x <= avg_d[0];
      avg_q.y <= avg_d[1];
      avg_q.z <= avg_d[2];
    end
  end

  assign m_valid_o = out_v_q;
  assign avg_o     = avg_q;
  assign verdict_o = out_verdict_q;
  assign stable_o  = stable_q;

`ifndef SYNTHESIS
  // a reported verdict always closes the group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && verdict_o) |-> !in_group_q)
    else $error("verdict reported with group still open");
`endif

endmodule

// ===== rtl/accel_window_average_stillness_top.sv =====
// ----------------------------------------------------------------------------
// accel_window_average_stillness_top: sliding window average with stillness
// Shift line of window cells, running sums per axis and a verdict stage.
//
//   port group   dir  contents
//   s_axis_*     in   raw sample request
//   m_axis_*     out  window averages and stillness verdict
//   cfg_*        in   register writes (threshold, stable count)
//
// one request per cycle sustained while the output is not stalled; a result passes
// through the sum register and then the verdict/output register
// the window cells shift once per request, the oldest leaves the last cell
// reset clears the sums, group state and registers, verdict reads stable;
// the window is not cleared, the first request fills every cell
// an output stall holds the verdict stage; if the sum stage is empty, one more
// request is taken into it before the input side stalls too
// ----------------------------------------------------------------------------
module accel_window_average_stillness_top #(
  parameter int unsigned WINDOW = awas_pkg::DefWindow
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,  // accel_x, accel_y, accel_z
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata,  // avg_x, avg_y, avg_z
  output logic [1:0]                    m_axis_tuser,  // verdict_valid, is_stable
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [awas_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [awas_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned LogW = $clog2(WINDOW);
  localparam int unsigned SumW = awas_pkg::SampleW + LogW;
  localparam logic signed [SumW-1:0] WinS = SumW'(WINDOW);

  awas_pkg::sample_t in_s;
  awas_pkg::sample_t chain [WINDOW+1];
  awas_pkg::sample_t oldest;
  awas_pkg::sample_t avg;
  awas_pkg::cfg_t    cfg_q;

  logic                   accept;
  logic                   primed_q;
  logic                   a_v_q;
  logic                   b_ready;
  logic                   verdict;
  logic                   stable;
  logic signed [SumW-1:0] sum_q [3];
  logic signed [SumW-1:0] sum_d [3];
  logic signed [SumW-1:0] ext_new [3];
  logic signed [SumW-1:0] ext_old [3];

  assign in_s          = awas_pkg::sample_t'(s_axis_tdata);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !a_v_q || b_ready;
  assign chain[0]      = in_s;
  assign oldest        = chain[WINDOW];

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    awas_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (accept),
      .fill_i      (!primed_q),
      .fill_data_i (in_s),
      .prev_i      (chain[g]),
      .data_o      (chain[g+1])
    );
  end

  assign ext_new[0] = {{LogW{in_s.x[15]}}, in_s.x};
  assign ext_new[1] = {{LogW{in_s.y[15]}}, in_s.y};
  assign ext_new[2] = {{LogW{in_s.z[15]}}, in_s.z};
  assign ext_old[0] = {{LogW{oldest.x[15]}}, oldest.x};
  assign ext_old[1] = {{LogW{oldest.y[15]}}, oldest.y};
  assign ext_old[2] = {{LogW{oldest.z[15]}}, oldest.z};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (!primed_q) begin
        sum_d[a] = ext_new[a] * WinS;
      end else begin
        sum_d[a] = sum_q[a] + ext_new[a] - ext_old[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '{default: '0};
      primed_q <= 1'b0;
      a_v_q    <= 1'b0;
    end else begin
      if (accept) begin
        sum_q    <= sum_d;
        primed_q <= 1'b1;
        a_v_q    <= 1'b1;
      end else if (b_ready) begin
        a_v_q <= 1'b0;
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= awas_pkg::ThresholdReset;
      cfg_q.stable_count <= awas_pkg::StableCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        awas_pkg::RegThreshold:   cfg_q.threshold    <= cfg_data_i;
        awas_pkg::RegStableCount: cfg_q.stable_count <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  awas_judge #(
    .WINDOW (WINDOW)
  ) u_judge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (a_v_q),
    .ready_o   (b_ready),
    .sum_i     (sum_q),
    .cfg_i     (cfg_q),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .avg_o     (avg),
    .verdict_o (verdict),
    .stable_o  (stable)
  );

  assign m_axis_tdata = avg;
  assign m_axis_tuser = {stable, verdict};

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (a_v_q && primed_q))
    else $error("accepted request did not reach the sum stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(a_v_q))
    else $error("result appeared without a request in the sum stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_v_q && !b_ready) |-> !s_axis_tready)
    else $error("request taken while sum stage is blocked");
`endif

endmodule
